### design/bfs_pkg.sv
package bfs_pkg;

  localparam int unsigned MaxBoids = 32;
  localparam int unsigned DataW    = 32;
  localparam int unsigned CfgW     = 31;
  localparam int unsigned DivW     = 64;

  // configuration register indexes
  localparam logic [2:0] CfgBoidCount = 3'd0;
  localparam logic [2:0] CfgCohDiv    = 3'd1;
  localparam logic [2:0] CfgSteerDiv  = 3'd2;
  localparam logic [2:0] CfgBufDist   = 3'd3;
  localparam logic [2:0] CfgSpeedLim  = 3'd4;

  localparam logic [5:0]      RstBoidCount = 6'd25;
  localparam logic [15:0]     RstCohDiv    = 16'd500;
  localparam logic [15:0]     RstSteerDiv  = 16'd50;
  localparam logic [CfgW-1:0] RstBufDist   = 31'd32000;
  localparam logic [CfgW-1:0] RstSpeedLim  = 31'd3840;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdStep = 1'b1;

  typedef struct packed {
    logic [2:0][DataW-1:0] pos;
    logic [2:0][DataW-1:0] vel;
  } boid_t;

  typedef struct packed {
    logic             start;
    logic [DivW-1:0]  dividend;
    logic [DataW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

endpackage

### design/bfs_div.sv
module bfs_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bfs_pkg::div_req_t  req_i,
  output bfs_pkg::div_rsp_t  rsp_o
);

  localparam int unsigned DivW  = bfs_pkg::DivW;
  localparam int unsigned DataW = bfs_pkg::DataW;
  localparam int unsigned CntW  = $clog2(DivW + 1);

  logic            busy_q, done_q, neg_q;
  logic [CntW-1:0] cnt_q;
  logic [DivW-1:0] num_q;
  logic [DataW-1:0] rem_q, den_q;
  logic [DataW:0]   rem_sh;
  logic [DataW+1:0] diff;

  assign rem_sh = {rem_q, num_q[DivW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // restoring division on magnitudes, one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.dividend[DivW-1];
      num_q <= req_i.dividend[DivW-1] ? -req_i.dividend : req_i.dividend;
      rem_q <= '0;
      den_q <= req_i.divisor;
    end else if (busy_q) begin
      if (!diff[DataW+1]) begin
        rem_q <= diff[DataW-1:0];
        num_q <= {num_q[DivW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DataW-1:0];
        num_q <= {num_q[DivW-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? -num_q : num_q;

endmodule

### design/boids_flocking_step_top.sv
// channel  | handshake              | payload
// cfg      | cfg_we_i               | cfg_idx_i, cfg_wdata_i
// in       | in_valid_i/in_ready_o  | cmd_i, boid_index_i, load_pos_*_i, load_vel_*_i
// out      | out_valid_o/out_ready_i| out_index_o, new_pos_*_o, new_vel_*_o, last_of_step_o
//
// A load writes one boid straight into memory. A step first squares the buffer distance plus one,
// then per boid reads its neighbors through the single memory read port, runs 15 divisions on
// the shared divider, takes the magnitude root and emits, with 3 more divisions when the speed
// limit applies.
// Reset sets the registers to their defaults; the boid memory is not cleared.
// A boid's result waits in the output register while the next boid is computed; that boid
// is emitted only once the waiting result has been taken, so a stalled output holds the step.
module boids_flocking_step_top #(
  parameter int unsigned MAX_BOIDS = bfs_pkg::MaxBoids
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [bfs_pkg::CfgW-1:0]      cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cmd_i,
  input  logic [4:0]                    boid_index_i,
  input  logic signed [31:0]            load_pos_x_i,
  input  logic signed [31:0]            load_pos_y_i,
  input  logic signed [31:0]            load_pos_z_i,
  input  logic signed [31:0]            load_vel_x_i,
  input  logic signed [31:0]            load_vel_y_i,
  input  logic signed [31:0]            load_vel_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [4:0]                    out_index_o,
  output logic signed [31:0]            new_pos_x_o,
  output logic signed [31:0]            new_pos_y_o,
  output logic signed [31:0]            new_pos_z_o,
  output logic signed [31:0]            new_vel_x_o,
  output logic signed [31:0]            new_vel_y_o,
  output logic signed [31:0]            new_vel_z_o,
  output logic                          last_of_step_o
);

  localparam int unsigned DataW = bfs_pkg::DataW;
  localparam int unsigned DivW  = bfs_pkg::DivW;
  localparam int unsigned CfgW  = bfs_pkg::CfgW;
  localparam int unsigned AW    = (MAX_BOIDS > 1) ? $clog2(MAX_BOIDS) : 1;
  localparam int unsigned CW    = $clog2(MAX_BOIDS + 1);
  localparam int unsigned SW    = DataW + $clog2(MAX_BOIDS) + 2;
  localparam int unsigned AccW  = SW + 2;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_BD     = 5'd1;
  localparam logic [4:0] S_BD2    = 5'd2;
  localparam logic [4:0] S_RDI    = 5'd3;
  localparam logic [4:0] S_GETI   = 5'd4;
  localparam logic [4:0] S_RDJ    = 5'd5;
  localparam logic [4:0] S_GETJ   = 5'd6;
  localparam logic [4:0] S_SQ     = 5'd7;
  localparam logic [4:0] S_CMP    = 5'd8;
  localparam logic [4:0] S_DSTART = 5'd9;
  localparam logic [4:0] S_DWAIT  = 5'd10;
  localparam logic [4:0] S_VSQ    = 5'd11;
  localparam logic [4:0] S_MAG    = 5'd12;
  localparam logic [4:0] S_SQRT   = 5'd13;
  localparam logic [4:0] S_LIMCHK = 5'd14;
  localparam logic [4:0] S_VLIM   = 5'd15;
  localparam logic [4:0] S_EMIT   = 5'd16;

  localparam logic [2:0] OpAvgPos = 3'd0;
  localparam logic [2:0] OpCoh    = 3'd1;
  localparam logic [2:0] OpSep    = 3'd2;
  localparam logic [2:0] OpAvgVel = 3'd3;
  localparam logic [2:0] OpAli    = 3'd4;
  localparam logic [2:0] OpDisp   = 3'd5;

  logic [5:0]      boid_count_q;
  logic [15:0]     coh_div_q, steer_div_q;
  logic [CfgW-1:0] buf_dist_q, speed_lim_q;

  logic [4:0]    state_q;
  logic [CW-1:0] i_q, j_q;
  logic [1:0]    k_q;
  logic [2:0]    op_q;
  logic          out_valid_q;

  bfs_pkg::boid_t mem_q [MAX_BOIDS];
  bfs_pkg::boid_t rd_q, mem_wd;
  logic           mem_we;
  logic [AW-1:0]  mem_wa, mem_ra;

  logic signed [DataW-1:0] p_q [3];
  logic signed [DataW-1:0] v_q [3];
  logic signed [SW-1:0]    sp_q [3];
  logic signed [SW-1:0]    sv_q [3];
  logic signed [SW-1:0]    sep_q [3];
  logic signed [DataW:0]   d_q [3];
  logic [DataW:0]          ad [3];
  logic [DataW-1:0]        av [3];
  logic [DataW-1:0]        ma [3];
  logic [DataW-1:0]        mb [3];
  logic [DivW-1:0]         prod_q [3];
  logic                    big_q;
  logic [DivW-1:0]         bd2_q;
  logic signed [AccW-1:0]  tmp_q, acc_q, qa, dif_p, dif_v, acc_sum;
  logic [DivW-1:0]         sx_q, sres_q, sbit_q, sq_try;
  logic [DivW+1:0]         sdist;
  logic [DataW-1:0]        bd1;

  logic [CW-1:0]  n_eff, m_eff;
  logic [6:0]     bc7;
  logic [15:0]    cdiv_eff, sdiv_eff;
  logic           in_fire, emit_go, load_ok, over_lim;

  bfs_pkg::div_req_t div_req;
  bfs_pkg::div_rsp_t div_rsp;

  bfs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign bc7 = {1'b0, boid_count_q};
  always_comb begin
    if (bc7 < 7'd2) begin
      n_eff = CW'(2);
    end else if (bc7 > 7'(MAX_BOIDS)) begin
      n_eff = CW'(MAX_BOIDS);
    end else begin
      n_eff = CW'(bc7);
    end
  end
  assign m_eff    = n_eff - 1'b1;
  assign cdiv_eff = (coh_div_q == '0) ? 16'd1 : coh_div_q;
  assign sdiv_eff = (steer_div_q == '0) ? 16'd1 : steer_div_q;
  assign bd1      = DataW'(buf_dist_q) + 1'b1;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign load_ok    = {2'b00, boid_index_i} < 7'(MAX_BOIDS);
  assign emit_go    = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);
  assign over_lim   = sres_q[DataW-1:0] > DataW'(speed_lim_q);

  // memory ports
  always_comb begin
    mem_we = 1'b0;
    mem_wa = AW'(boid_index_i);
    mem_wd.pos = {load_pos_z_i, load_pos_y_i, load_pos_x_i};
    mem_wd.vel = {load_vel_z_i, load_vel_y_i, load_vel_x_i};
    if (emit_go) begin
      mem_we = 1'b1;
      mem_wa = i_q[AW-1:0];
      mem_wd.pos = {p_q[2], p_q[1], p_q[0]};
      mem_wd.vel = {v_q[2], v_q[1], v_q[0]};
    end else if (in_fire && cmd_i == bfs_pkg::CmdLoad && load_ok) begin
      mem_we = 1'b1;
    end
    mem_ra = (state_q == S_RDI) ? i_q[AW-1:0] : j_q[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_q <= mem_q[mem_ra];
  end

  // multiplier lanes
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ad[k] = d_q[k][DataW] ? DataW'(0) - d_q[k] : d_q[k];
      av[k] = v_q[k][DataW-1] ? -v_q[k] : v_q[k];
      ma[k] = '0;
      mb[k] = '0;
      case (state_q)
        S_BD: begin
          ma[k] = bd1;
          mb[k] = bd1;
        end
        S_SQ: begin
          ma[k] = ad[k][DataW-1:0];
          mb[k] = ad[k][DataW-1:0];
        end
        S_VSQ: begin
          ma[k] = av[k];
          mb[k] = av[k];
        end
        S_VLIM: begin
          ma[k] = av[k];
          mb[k] = DataW'(speed_lim_q);
        end
        default: begin
          ma[k] = '0;
        end
      endcase
    end
  end

  // divider operands
  assign qa      = div_rsp.quotient[AccW-1:0];
  assign dif_p   = tmp_q - AccW'(p_q[k_q]);
  assign dif_v   = tmp_q - AccW'(v_q[k_q]);
  assign acc_sum = acc_q + qa;

  always_comb begin
    div_req.start    = (state_q == S_DSTART);
    div_req.dividend = DivW'(sp_q[k_q]);
    div_req.divisor  = DataW'(m_eff);
    case (op_q)
      OpAvgPos: begin
        div_req.dividend = DivW'(sp_q[k_q]);
        div_req.divisor  = DataW'(m_eff);
      end
      OpCoh: begin
        div_req.dividend = DivW'(dif_p);
        div_req.divisor  = DataW'(cdiv_eff);
      end
      OpSep: begin
        div_req.dividend = DivW'(sep_q[k_q]);
        div_req.divisor  = DataW'(sdiv_eff);
      end
      OpAvgVel: begin
        div_req.dividend = DivW'(sv_q[k_q]);
        div_req.divisor  = DataW'(m_eff);
      end
      OpAli: begin
        div_req.dividend = DivW'(dif_v);
        div_req.divisor  = DataW'(sdiv_eff);
      end
      OpDisp: begin
        div_req.dividend = v_q[k_q][DataW-1] ? -prod_q[k_q] : prod_q[k_q];
        div_req.divisor  = sres_q[DataW-1:0];
      end
      default: begin
        div_req.divisor = DataW'(m_eff);
      end
    endcase
  end

  assign sdist  = (DivW+2)'(prod_q[0]) + (DivW+2)'(prod_q[1]) + (DivW+2)'(prod_q[2]);
  assign sq_try = sres_q + sbit_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boid_count_q <= bfs_pkg::RstBoidCount;
      coh_div_q    <= bfs_pkg::RstCohDiv;
      steer_div_q  <= bfs_pkg::RstSteerDiv;
      buf_dist_q   <= bfs_pkg::RstBufDist;
      speed_lim_q  <= bfs_pkg::RstSpeedLim;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bfs_pkg::CfgBoidCount: boid_count_q <= cfg_wdata_i[5:0];
        bfs_pkg::CfgCohDiv:    coh_div_q    <= cfg_wdata_i[15:0];
        bfs_pkg::CfgSteerDiv:  steer_div_q  <= cfg_wdata_i[15:0];
        bfs_pkg::CfgBufDist:   buf_dist_q   <= cfg_wdata_i;
        bfs_pkg::CfgSpeedLim:  speed_lim_q  <= cfg_wdata_i;
        default: begin
          boid_count_q <= boid_count_q;
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      op_q        <= OpAvgPos;
      out_valid_q <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire && cmd_i == bfs_pkg::CmdStep) begin
            i_q     <= '0;
            state_q <= S_BD;
          end
        end
        S_BD:   state_q <= S_BD2;
        S_BD2:  state_q <= S_RDI;
        S_RDI: begin
          j_q     <= '0;
          state_q <= S_GETI;
        end
        S_GETI: state_q <= S_RDJ;
        S_RDJ: begin
          if (j_q == n_eff) begin
            op_q    <= OpAvgPos;
            k_q     <= '0;
            state_q <= S_DSTART;
          end else if (j_q == i_q) begin
            j_q <= j_q + 1'b1;
          end else begin
            state_q <= S_GETJ;
          end
        end
        S_GETJ: state_q <= S_SQ;
        S_SQ:   state_q <= S_CMP;
        S_CMP: begin
          j_q     <= j_q + 1'b1;
          state_q <= S_RDJ;
        end
        S_DSTART: state_q <= S_DWAIT;
        S_DWAIT: begin
          if (div_rsp.done) begin
            if (op_q == OpAli) begin
              op_q <= OpAvgPos;
              if (k_q == 2'd2) begin
                k_q     <= '0;
                state_q <= S_VSQ;
              end else begin
                k_q     <= k_q + 1'b1;
                state_q <= S_DSTART;
              end
            end else if (op_q == OpDisp) begin
              if (k_q == 2'd2) begin
                state_q <= S_EMIT;
              end else begin
                k_q     <= k_q + 1'b1;
                state_q <= S_DSTART;
              end
            end else begin
              op_q    <= op_q + 1'b1;
              state_q <= S_DSTART;
            end
          end
        end
        S_VSQ: state_q <= S_MAG;
        S_MAG: state_q <= S_SQRT;
        S_SQRT: begin
          if (sbit_q == DivW'(1)) begin
            state_q <= S_LIMCHK;
          end
        end
        S_LIMCHK: state_q <= over_lim ? S_VLIM : S_EMIT;
        S_VLIM: begin
          op_q    <= OpDisp;
          k_q     <= '0;
          state_q <= S_DSTART;
        end
        S_EMIT: begin
          if (emit_go) begin
            if (i_q == m_eff) begin
              state_q <= S_IDLE;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= S_RDI;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (state_q == S_BD || state_q == S_SQ || state_q == S_VSQ || state_q == S_VLIM) begin
      for (int k = 0; k < 3; k++) begin
        prod_q[k] <= ma[k] * mb[k];
      end
    end
    case (state_q)
      S_BD2: bd2_q <= prod_q[0];
      S_GETI: begin
        for (int k = 0; k < 3; k++) begin
          p_q[k]   <= $signed(rd_q.pos[k]);
          v_q[k]   <= $signed(rd_q.vel[k]);
          sp_q[k]  <= '0;
          sv_q[k]  <= '0;
          sep_q[k] <= '0;
        end
      end
      S_GETJ: begin
        for (int k = 0; k < 3; k++) begin
          sp_q[k] <= sp_q[k] + SW'($signed(rd_q.pos[k]));
          sv_q[k] <= sv_q[k] + SW'($signed(rd_q.vel[k]));
          d_q[k]  <= (DataW+1)'($signed(rd_q.pos[k])) - (DataW+1)'(p_q[k]);
        end
      end
      S_SQ: begin
        // distances of 2^31 or more are never within the radius
        big_q <= ad[0][DataW] | ad[0][DataW-1] | ad[1][DataW] | ad[1][DataW-1]
               | ad[2][DataW] | ad[2][DataW-1];
      end
      S_CMP: begin
        if (!big_q && sdist < {2'b00, bd2_q}) begin
          for (int k = 0; k < 3; k++) begin
            sep_q[k] <= sep_q[k] - SW'(d_q[k]);
          end
        end
      end
      S_DWAIT: begin
        if (div_rsp.done) begin
          case (op_q)
            OpAvgPos: tmp_q <= qa;
            OpCoh:    acc_q <= AccW'(v_q[k_q]) + qa;
            OpSep:    acc_q <= acc_sum;
            OpAvgVel: tmp_q <= qa;
            OpAli:    v_q[k_q] <= acc_sum[DataW-1:0];
            OpDisp:   p_q[k_q] <= p_q[k_q] + div_rsp.quotient[DataW-1:0];
            default:  tmp_q <= tmp_q;
          endcase
        end
      end
      S_MAG: begin
        sx_q   <= sdist[DivW-1:0];
        sres_q <= '0;
        sbit_q <= DivW'(1) << (DivW - 2);
      end
      S_SQRT: begin
        if (sx_q >= sq_try) begin
          sx_q   <= sx_q - sq_try;
          sres_q <= (sres_q >> 1) + sbit_q;
        end else begin
          sres_q <= sres_q >> 1;
        end
        sbit_q <= sbit_q >> 2;
      end
      S_LIMCHK: begin
        if (!over_lim) begin
          for (int k = 0; k < 3; k++) begin
            p_q[k] <= p_q[k] + v_q[k];
          end
        end
      end
      default: begin
        big_q <= big_q;
      end
    endcase
    if (emit_go) begin
      out_index_o    <= 5'(i_q);
      new_pos_x_o    <= p_q[0];
      new_pos_y_o    <= p_q[1];
      new_pos_z_o    <= p_q[2];
      new_vel_x_o    <= v_q[0];
      new_vel_y_o    <= v_q[1];
      new_vel_z_o    <= v_q[2];
      last_of_step_o <= (i_q == m_eff);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### design/bfs_checker.sv
module bfs_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              cmd_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [4:0]        out_index_o,
  input logic signed [31:0] new_pos_x_o,
  input logic              last_of_step_o
);

  logic [4:0] exp_idx_q;

  // track which boid the next result must carry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_idx_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      exp_idx_q <= last_of_step_o ? 5'd0 : out_index_o + 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_index_o)
      && $stable(new_pos_x_o) && $stable(last_of_step_o))
    else $error("stalled result changed");

  a_index_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_index_o == exp_idx_q)
    else $error("result out of boid order");

  a_busy_mid_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_step_o |-> !in_ready_o)
    else $error("request taken in the middle of a step");

  a_step_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && cmd_i == bfs_pkg::CmdStep |=> !in_ready_o)
    else $error("step request did not start a step");

endmodule

bind boids_flocking_step_top bfs_checker u_bfs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .cmd_i          (cmd_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .out_index_o    (out_index_o),
  .new_pos_x_o    (new_pos_x_o),
  .last_of_step_o (last_of_step_o)
);
